// File: rtl/omi_pkg.sv
// Shared types, constants and helpers of the obstacle map inflation unit.
// Depends on nothing; every other file of the block imports it.
package omi_pkg;

    // Default map dimensions, handed to the top level as parameter defaults.
    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 256;

    // Depth of the command queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;

    // Field widths fixed by the interface.
    localparam int COORD_W = 8;
    localparam int CHAN_W  = 8;
    localparam int SIZE_W  = 9;
    localparam int ROBOT_W = 8;
    localparam int HALF_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_X    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_Y    = 2'd3;

    // Input word modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Reciprocal of ten in 11 fractional bits; exact for all byte values.
    localparam int RECIP_TEN   = 205;
    localparam int RECIP_SHIFT = 11;

    typedef enum logic [1:0] {
        CMD_RESULT,
        CMD_QUERY,
        CMD_MARK
    } t_cmd_kind;

    // One classified word as it waits in the queue.
    typedef struct packed {
        t_cmd_kind            kind;
        logic                 blocked;
        logic                 oor;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   row_end;
        logic [COORD_W-1:0]   col;
        logic [COORD_W-1:0]   col_end;
    } t_cmd;

    // Configuration as the front end sees it.
    typedef struct packed {
        logic [SIZE_W-1:0] map_width;
        logic [SIZE_W-1:0] map_height;
        logic [HALF_W-1:0] half_x;
        logic [HALF_W-1:0] half_y;
    } t_cfg;

    // Half span of the robot: its size divided by ten.
    function automatic logic [HALF_W-1:0] half_span(input logic [ROBOT_W-1:0] size);
        logic [15:0] prod;
        prod = 16'(size) * 16'(RECIP_TEN);
        return prod[RECIP_SHIFT +: HALF_W];
    endfunction

endpackage

// File: rtl/omi_cmd_queue.sv
// Short command queue between the classifying front end and the map engine.
// Depends on omi_pkg for the command type and the queue depth.
module omi_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  omi_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output omi_pkg::t_cmd  o_cmd
);
    import omi_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/omi_front.sv
// Front end: accepts input words, checks them against the map size and
// turns each into a command for the queue. Depends on omi_pkg.
module omi_front #(
    parameter int MAX_COLS = omi_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = omi_pkg::DEF_MAX_ROWS
) (
    input  logic                          i_s_valid,
    output logic                          o_s_ready,
    input  logic                          i_mode,
    input  logic [omi_pkg::S_DATA_W-1:0]  i_data,
    input  omi_pkg::t_cfg                 i_cfg,
    input  logic                          i_clearing,
    input  logic                          i_q_full,
    output logic                          o_push,
    output omi_pkg::t_cmd                 o_cmd
);
    import omi_pkg::*;

    logic [COORD_W-1:0] col, row;
    logic [CHAN_W-1:0]  red, green, blue;
    logic [SIZE_W-1:0]  cols_eff, rows_eff;
    logic [SIZE_W-1:0]  col_lim, row_lim;
    logic [SIZE_W-1:0]  col_sum, row_sum;
    logic [COORD_W-1:0] col_cap, row_cap;
    logic               outside;
    logic               is_black;

    assign col   = i_data[0  +: COORD_W];
    assign row   = i_data[8  +: COORD_W];
    assign red   = i_data[16 +: CHAN_W];
    assign green = i_data[24 +: CHAN_W];
    assign blue  = i_data[32 +: CHAN_W];

    assign o_s_ready = !i_q_full && !i_clearing;
    assign o_push    = i_s_valid && o_s_ready;

    always_comb begin
        // The map in use is the smaller of the register and the array.
        cols_eff = (32'(i_cfg.map_width) > MAX_COLS) ? SIZE_W'(MAX_COLS) : i_cfg.map_width;
        rows_eff = (32'(i_cfg.map_height) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : i_cfg.map_height;
        outside  = ({1'b0, col} >= cols_eff) || ({1'b0, row} >= rows_eff);
        is_black = (red == '0) && (green == '0) && (blue == '0);

        // Far edges of the rectangle. Coordinates never exceed a byte, so
        // anything beyond the last byte value can never be queried.
        col_lim = cols_eff - 1'b1;
        row_lim = rows_eff - 1'b1;
        col_cap = col_lim[SIZE_W-1] ? '1 : col_lim[COORD_W-1:0];
        row_cap = row_lim[SIZE_W-1] ? '1 : row_lim[COORD_W-1:0];
        col_sum = {1'b0, col} + SIZE_W'(i_cfg.half_x);
        row_sum = {1'b0, row} + SIZE_W'(i_cfg.half_y);

        o_cmd         = '0;
        o_cmd.kind    = CMD_RESULT;
        o_cmd.oor     = outside;
        o_cmd.row     = row;
        o_cmd.col     = col;
        o_cmd.row_end = (row_sum > {1'b0, row_cap}) ? row_cap : row_sum[COORD_W-1:0];
        o_cmd.col_end = (col_sum > {1'b0, col_cap}) ? col_cap : col_sum[COORD_W-1:0];

        if (i_mode == MODE_QUERY) begin
            if (outside) begin
                o_cmd.blocked = 1'b1;
            end else begin
                o_cmd.kind = CMD_QUERY;
            end
        end else if (!outside && is_black) begin
            o_cmd.kind = CMD_MARK;
            o_cmd.row  = (row > COORD_W'(i_cfg.half_y)) ? row - COORD_W'(i_cfg.half_y) : '0;
            o_cmd.col  = (col > COORD_W'(i_cfg.half_x)) ? col - COORD_W'(i_cfg.half_x) : '0;
        end
    end

endmodule

// File: rtl/omi_back.sv
// Back end: owns the occupancy memory, clears it after reset, marks
// rectangles row by row and answers queries. Depends on omi_pkg.
module omi_back #(
    parameter int MAX_COLS = omi_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = omi_pkg::DEF_MAX_ROWS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  omi_pkg::t_cmd  i_q_cmd,
    output logic           o_q_pop,
    output logic           o_clearing,
    output logic           o_m_valid,
    input  logic           i_m_ready,
    output logic           o_blocked,
    output logic           o_oor
);
    import omi_pkg::*;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MARK
    } t_state;

    t_state              r_state;
    logic [ROW_W-1:0]    r_clr_addr;
    logic [COORD_W-1:0]  r_cur;
    logic [COORD_W-1:0]  r_end;
    logic [COORD_W-1:0]  r_c0;
    logic [COORD_W-1:0]  r_c1;
    logic [COORD_W-1:0]  r_col;
    logic                r_out_valid;
    logic                r_out_blocked;
    logic                r_out_oor;

    logic [MAX_COLS-1:0] r_map [MAX_ROWS];
    logic [MAX_COLS-1:0] r_rd_row;

    logic                slot_free;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_addr;
    logic [MAX_COLS-1:0] wr_mask;
    logic                wr_bit;
    logic [MAX_COLS-1:0] col_mask;
    logic                rd_en;

    assign slot_free  = !r_out_valid || i_m_ready;
    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid && slot_free;
    assign rd_en      = o_q_pop && (i_q_cmd.kind == CMD_QUERY);
    assign o_clearing = (r_state == ST_CLEAR);
    assign o_m_valid  = r_out_valid;
    assign o_blocked  = r_out_blocked;
    assign o_oor      = r_out_oor;

    always_comb begin
        for (int b = 0; b < MAX_COLS; b++) begin
            col_mask[b] = (b >= int'(r_c0)) && (b <= int'(r_c1));
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_mask = '0;
        wr_bit  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_mask = '1;
            end
            ST_MARK: begin
                wr_en   = 1'b1;
                wr_addr = ROW_W'(r_cur);
                wr_mask = col_mask;
                wr_bit  = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Row-wide write with a per-cell enable, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int b = 0; b < MAX_COLS; b++) begin
                if (wr_mask[b]) begin
                    r_map[wr_addr][b] <= wr_bit;
                end
            end
        end
        if (rd_en) begin
            r_rd_row <= r_map[ROW_W'(i_q_cmd.row)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    if (r_clr_addr == ROW_W'(MAX_ROWS - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (o_q_pop) begin
                        case (i_q_cmd.kind)
                            CMD_QUERY: begin
                                r_col   <= i_q_cmd.col;
                                r_state <= ST_READ;
                            end
                            CMD_MARK: begin
                                r_cur         <= i_q_cmd.row;
                                r_end         <= i_q_cmd.row_end;
                                r_c0          <= i_q_cmd.col;
                                r_c1          <= i_q_cmd.col_end;
                                r_out_valid   <= 1'b1;
                                r_out_blocked <= 1'b0;
                                r_out_oor     <= 1'b0;
                                r_state       <= ST_MARK;
                            end
                            default: begin
                                r_out_valid   <= 1'b1;
                                r_out_blocked <= i_q_cmd.blocked;
                                r_out_oor     <= i_q_cmd.oor;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    r_out_valid   <= 1'b1;
                    r_out_blocked <= r_rd_row[COL_W'(r_col)];
                    r_out_oor     <= 1'b0;
                    r_state       <= ST_IDLE;
                end
                ST_MARK: begin
                    if (r_cur == r_end) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_cur <= r_cur + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/obstacle_map_inflation_unit.sv
// Top level of the obstacle map inflation unit: configuration registers,
// front end, command queue and map engine. Depends on omi_pkg and all omi_ modules.
//
//  Channel  Direction  Handshake                      Contents
//  s_axis   in         s_axis_tvalid / s_axis_tready  one load or query word
//  m_axis   out        m_axis_tvalid / m_axis_tready  one result word per input word
//  cfg      in         i_cfg_we                       register write, no back-pressure
//
// After reset the map memory is swept clear, one row per cycle, from the first
// row to the last; s_axis_tready stays low during that sweep.
// A query passes the queue slot, the registered read of the map row and the
// output register before its result word appears.
// A black pixel occupies the map engine while it marks its rows, one after the
// other, since the map memory takes one row-wide masked write per cycle. Other
// loads and out-of-range queries give their result straight from the queue entry.
// The front end keeps accepting words until the queue is full while the engine
// marks, and the output register lets marking go on while a result word waits.
module obstacle_map_inflation_unit #(
    parameter int MAX_COLS = omi_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = omi_pkg::DEF_MAX_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [omi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [omi_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0: col[7:0], row[15:8], red[23:16], green[31:24], blue[39:32]
    input  logic [omi_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // tuser: mode[0] (0 load a pixel, 1 query a cell)
    input  logic                            s_axis_tuser,
    // Output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata from bit 0: blocked[0], out_of_range[1], zero padding[7:2]
    output logic [omi_pkg::M_DATA_W-1:0]    m_axis_tdata
);
    import omi_pkg::*;

    logic [SIZE_W-1:0] r_map_width;
    logic [SIZE_W-1:0] r_map_height;
    logic [HALF_W-1:0] r_half_x;
    logic [HALF_W-1:0] r_half_y;

    t_cfg cfg;
    t_cmd push_cmd;
    t_cmd q_cmd;
    logic push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic clearing;
    logic blocked;
    logic oor;

    // The robot sizes are kept as half spans, divided by ten as they are written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= SIZE_W'(256);
            r_map_height <= SIZE_W'(256);
            r_half_x     <= '0;
            r_half_y     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAP_WIDTH:  r_map_width  <= i_cfg_wdata;
                CFG_MAP_HEIGHT: r_map_height <= i_cfg_wdata;
                CFG_ROBOT_X:    r_half_x     <= half_span(i_cfg_wdata[ROBOT_W-1:0]);
                CFG_ROBOT_Y:    r_half_y     <= half_span(i_cfg_wdata[ROBOT_W-1:0]);
                default:        r_map_width  <= r_map_width;
            endcase
        end
    end

    assign cfg.map_width  = r_map_width;
    assign cfg.map_height = r_map_height;
    assign cfg.half_x     = r_half_x;
    assign cfg.half_y     = r_half_y;

    // Classifies each word against the map size and works out the clipped rectangle.
    omi_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_mode     (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .i_cfg      (cfg),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    omi_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Holds the map, runs the clearing sweep and the row-by-row marking.
    omi_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_blocked  (blocked),
        .o_oor      (oor)
    );

    assign m_axis_tdata = {6'b0, oor, blocked};

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for obstacle_map_inflation_unit: stream stimulus, a scoreboard
// that models the occupancy map, and checks of every result word in order.
// Depends on omi_pkg and the RTL of the unit.
module tb_top;

    import omi_pkg::*;

    // Size of the modelled map; it matches the parameter defaults of the unit.
    localparam int MAP_COLS  = DEF_MAX_COLS;
    localparam int MAP_ROWS  = DEF_MAX_ROWS;
    localparam int MAP_CELLS = MAP_COLS * MAP_ROWS;
    // A black pixel may keep the engine marking after its result word has left,
    // so every quiet point also waits out any marking still under way.
    localparam int ENGINE_TAIL = 64;
    // Generous ceiling for the whole run, several times the slowest correct run.
    localparam time RUN_LIMIT = 5_000_000ns;

    // Fields of one result word.
    typedef struct packed {
        logic blocked;
        logic out_of_range;
    } t_result;

    // Scoreboard: keeps its own occupancy map and register copies, works out the
    // result of every accepted input word and compares result words in order.
    class occupancy_scoreboard;
        bit          occupied [MAP_CELLS];
        logic [8:0]  map_width;
        logic [8:0]  map_height;
        logic [7:0]  robot_x;
        logic [7:0]  robot_y;
        t_result     expected_q [$];
        int          errors;

        function void clear();
            foreach (occupied[i]) occupied[i] = 1'b0;
            map_width  = 9'd256;
            map_height = 9'd256;
            robot_x    = 8'd0;
            robot_y    = 8'd0;
            errors     = 0;
            expected_q.delete();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_MAP_WIDTH:  map_width  = value;
                CFG_MAP_HEIGHT: map_height = value;
                CFG_ROBOT_X:    robot_x    = value[7:0];
                CFG_ROBOT_Y:    robot_y    = value[7:0];
                default: ;
            endcase
        endfunction

        function int cols_in_use();
            return (map_width < MAP_COLS) ? int'(map_width) : MAP_COLS;
        endfunction

        function int rows_in_use();
            return (map_height < MAP_ROWS) ? int'(map_height) : MAP_ROWS;
        endfunction

        // Called for every accepted input word, in acceptance order.
        function void note_word(logic mode, logic [S_DATA_W-1:0] data);
            int      col, row, cols, rows, half_x, half_y, r0, r1, c0, c1;
            bit      outside;
            t_result res;
            col     = int'(data[7:0]);
            row     = int'(data[15:8]);
            cols    = cols_in_use();
            rows    = rows_in_use();
            outside = (col >= cols) || (row >= rows);
            res.out_of_range = outside;
            res.blocked      = 1'b0;
            if (mode == MODE_QUERY) begin
                res.blocked = outside || occupied[row * MAP_COLS + col];
            end else if (!outside && data[39:16] == 24'd0) begin
                // Black pixel: mark the robot-sized rectangle, clipped to the map.
                half_x = int'(robot_x) / 10;
                half_y = int'(robot_y) / 10;
                r0 = (row > half_y) ? row - half_y : 0;
                c0 = (col > half_x) ? col - half_x : 0;
                r1 = (row + half_y > rows - 1) ? rows - 1 : row + half_y;
                c1 = (col + half_x > cols - 1) ? cols - 1 : col + half_x;
                for (int r = r0; r <= r1; r++) begin
                    for (int c = c0; c <= c1; c++) begin
                        occupied[r * MAP_COLS + c] = 1'b1;
                    end
                end
            end
            expected_q.push_back(res);
        endfunction

        // Called for every accepted result word.
        function void check_result(logic [M_DATA_W-1:0] data);
            t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: result word %0h arrived with nothing expected", $time, data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (data[0] !== want.blocked) begin
                $display("%0t: blocked expected %0b, actual %0b",
                         $time, want.blocked, data[0]);
                errors++;
            end
            if (data[1] !== want.out_of_range) begin
                $display("%0t: out_of_range expected %0b, actual %0b",
                         $time, want.out_of_range, data[1]);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // tdata from bit 0: col[7:0], row[15:8], red[23:16], green[31:24], blue[39:32]
    logic [S_DATA_W-1:0]     s_axis_tdata;
    // tuser: mode[0] (0 load a pixel, 1 query a cell)
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // tdata from bit 0: blocked[0], out_of_range[1], zero padding[7:2]
    logic [M_DATA_W-1:0]     m_axis_tdata;

    occupancy_scoreboard sb;

    // Where the most recent black pixel inside the map was loaded, so that random
    // queries can be aimed at its marked neighbourhood.
    int last_col;
    int last_row;
    bit have_black;

    // Receiver stall pattern state, used only by the receiver process.
    int rx_cycle = 0;
    int rx_style = 0;

    obstacle_map_inflation_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Both handshakes are sampled at the rising edge, before any of that edge's
    // updates land, so the scoreboard sees exactly what the unit accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_word(s_axis_tuser, s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
            end
        end
    end

    // The receiver switches at random between four habits: always ready, coin-toss
    // ready, ready one cycle in seven, or alternating ready and stalled runs.
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 256 == 0) begin
            rx_style = $urandom_range(0, 3);
        end
        case (rx_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (rx_cycle % 7 == 0);
            default: m_axis_tready <= ((rx_cycle / 16) % 2 == 0);
        endcase
    end

    // Presents one word and holds it until the unit takes it. On return the
    // word has been accepted at the current edge.
    task automatic push_word(input logic mode, input logic [7:0] col, input logic [7:0] row,
                             input logic [23:0] rgb);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {rgb, row, col};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic idle_gap(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stops sending and waits until every result word has come back and the
    // engine has had time to finish any marking still under way. The first edge
    // lets the scoreboard note the word accepted just before.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (ENGINE_TAIL) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
    endtask

    // Writes all four registers; only called while the unit is quiet.
    task automatic write_regs(input logic [8:0] width, input logic [8:0] height,
                              input logic [7:0] size_x, input logic [7:0] size_y);
        write_reg(CFG_MAP_WIDTH,  width);
        write_reg(CFG_MAP_HEIGHT, height);
        write_reg(CFG_ROBOT_X,    {1'b0, size_x});
        write_reg(CFG_ROBOT_Y,    {1'b0, size_y});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One random word. Most coordinates fall inside the map in use; a share of
    // queries is aimed around the last black pixel so that marked cells and the
    // rim of each rectangle are hit, and some words use the full coordinate range.
    task automatic push_random_word();
        logic        mode;
        logic [23:0] rgb;
        int          cols, rows, half_x, half_y, c, r;
        cols   = sb.cols_in_use();
        rows   = sb.rows_in_use();
        half_x = int'(sb.robot_x) / 10;
        half_y = int'(sb.robot_y) / 10;
        mode   = $urandom_range(0, 1) ? MODE_QUERY : MODE_LOAD;
        if (cols == 0 || rows == 0 || $urandom_range(0, 99) < 12) begin
            c = $urandom_range(0, 255);
            r = $urandom_range(0, 255);
        end else if (mode == MODE_QUERY && have_black && $urandom_range(0, 99) < 60) begin
            c = last_col - half_x - 1 + int'($urandom_range(0, 2 * half_x + 2));
            r = last_row - half_y - 1 + int'($urandom_range(0, 2 * half_y + 2));
            if (c < 0 || c > 255) c = $urandom_range(0, cols - 1);
            if (r < 0 || r > 255) r = $urandom_range(0, rows - 1);
        end else begin
            c = $urandom_range(0, cols - 1);
            r = $urandom_range(0, rows - 1);
        end
        if ($urandom_range(0, 99) < 35) begin
            rgb = 24'd0;
        end else begin
            rgb = 24'($urandom);
            // Zero single channels often, so near-black pixels show up too.
            for (int k = 0; k < 3; k++) begin
                if ($urandom_range(0, 3) == 0) rgb[8*k +: 8] = 8'd0;
            end
        end
        if (mode == MODE_LOAD && rgb == 24'd0 && c < cols && r < rows) begin
            last_col   = c;
            last_row   = r;
            have_black = 1'b1;
        end
        push_word(mode, c[7:0], r[7:0], rgb);
    endtask

    // Random traffic in bursts of random length; about half the bursts follow
    // the previous one without a gap.
    task automatic run_random(input int items);
        int burst_left;
        burst_left = 0;
        for (int n = 0; n < items; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 1) == 1) idle_gap($urandom_range(1, 8));
            end
            burst_left--;
            push_random_word();
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_MAP_WIDTH;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= MODE_LOAD;
        s_axis_tdata  <= '0;
        have_black    = 1'b0;
        last_col      = 0;
        last_row      = 0;
        sb = new();
        sb.clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // The unit sweeps its map clear after reset and holds tready low meanwhile.
        while (!s_axis_tready) @(posedge i_clk);

        // Reset settings: full map, robot of zero size, so a black pixel marks
        // only its own cell. Corners of the coordinate range and a white pixel.
        push_word(MODE_QUERY, 8'd0,   8'd0,   24'hFFFFFF);
        push_word(MODE_QUERY, 8'd255, 8'd255, 24'h000000);
        push_word(MODE_LOAD,  8'd0,   8'd0,   24'h000000);
        push_word(MODE_QUERY, 8'd0,   8'd0,   24'h000000);
        push_word(MODE_QUERY, 8'd1,   8'd0,   24'h000000);
        push_word(MODE_LOAD,  8'd5,   8'd5,   24'hFFFFFF);
        push_word(MODE_QUERY, 8'd5,   8'd5,   24'h000000);
        push_word(MODE_LOAD,  8'd255, 8'd255, 24'h000000);
        push_word(MODE_QUERY, 8'd255, 8'd255, 24'h000000);
        settle();

        // Small map with the widest column span: black pixels at the far corner
        // and near the top-left are clipped, and loads outside the map do nothing.
        write_regs(9'd20, 9'd12, 8'd255, 8'd35);
        push_word(MODE_LOAD,  8'd19, 8'd11, 24'h000000);
        push_word(MODE_QUERY, 8'd0,  8'd8,  24'h000000);
        push_word(MODE_QUERY, 8'd20, 8'd5,  24'h000000);
        push_word(MODE_LOAD,  8'd25, 8'd3,  24'h000000);
        push_word(MODE_QUERY, 8'd25, 8'd3,  24'h000000);
        push_word(MODE_LOAD,  8'd2,  8'd1,  24'h000000);
        push_word(MODE_QUERY, 8'd19, 8'd0,  24'h000000);
        settle();

        // Zero width: every coordinate lies outside the map.
        write_regs(9'd0, 9'd12, 8'd255, 8'd35);
        push_word(MODE_QUERY, 8'd0, 8'd0, 24'h000000);
        push_word(MODE_LOAD,  8'd0, 8'd0, 24'h000000);
        settle();

        // Sizes beyond the map clamp to it; tallest row span marks 51 rows.
        write_regs(9'd300, 9'd511, 8'd9, 8'd250);
        push_word(MODE_LOAD,  8'd128, 8'd200, 24'h000000);
        push_word(MODE_QUERY, 8'd128, 8'd175, 24'h000000);
        push_word(MODE_QUERY, 8'd128, 8'd174, 24'h000000);
        push_word(MODE_QUERY, 8'd129, 8'd200, 24'h000000);
        push_word(MODE_QUERY, 8'd128, 8'd225, 24'h000000);
        settle();

        // Random phases over several settings, extremes among them. Marks from
        // earlier phases stay in the map and are read back under new sizes.
        write_regs(9'd16, 9'd16, 8'd25, 8'd25);
        run_random(100);
        settle();
        write_regs(9'd1, 9'd1, 8'd0, 8'd0);
        run_random(60);
        settle();
        write_regs(9'd256, 9'd256, 8'd250, 8'd250);
        run_random(100);
        settle();
        write_regs(9'd40, 9'd8, 8'd99, 8'd5);
        run_random(100);
        settle();
        write_regs(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random(80);
        settle();
        write_regs(9'd256, 9'd64, 8'd0, 8'd255);
        run_random(80);
        settle();
        write_regs(9'd33, 9'd50, 8'd19, 8'd10);
        run_random(80);
        settle();

        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        #(RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
